@@ sv/njs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// njs_pkg
// Shared types and constants of the non-preemptive job scheduler: job record,
// sequencer states, scan control bundle and the selection key function.
// ----------------------------------------------------------------------------
package njs_pkg;

   localparam int ID_W    = 8;
   localparam int ARR_W   = 16;
   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int KEY_W   = 16;
   localparam int TIME_W  = 22;

   // select_mode codes
   localparam logic MODE_BURST = 1'b0;
   localparam logic MODE_PRIO  = 1'b1;

   // one job as held in the table memory
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
   } job_rec_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_PICK
   } sched_state_type;

   // control from the sequencer to the selection tracker
   typedef struct packed {
      logic clear;
      logic valid;
   } scan_ctl_type;

   // ordering key of a job under the current mode
   function automatic logic [KEY_W-1:0] key_of(input job_rec_type rec, input logic mode);
      logic [KEY_W-1:0] key;
      key = '0;
      case (mode)
         MODE_PRIO: key = KEY_W'(rec.prio);
         default:   key = KEY_W'(rec.burst);
      endcase
      return key;
   endfunction

endpackage
`default_nettype wire

@@ sv/njs_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// njs channel interfaces
// Valid/ready channels of the job scheduler: job input, schedule output and
// the mode register write port.
// ----------------------------------------------------------------------------

// job input channel
interface njs_req_if import njs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ID_W-1:0]     job_id;
   logic [ARR_W-1:0]    arrival_time;
   logic [BURST_W-1:0]  burst_length;
   logic [PRIO_W-1:0]   job_priority;
   logic                last_job;

   modport source (output valid, job_id, arrival_time, burst_length, job_priority,
                   last_job, input ready);
   modport sink   (input valid, job_id, arrival_time, burst_length, job_priority,
                   last_job, output ready);
endinterface

// schedule segment channel
interface njs_rsp_if import njs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ID_W-1:0]    run_id;
   logic [TIME_W-1:0]  start_time;
   logic [TIME_W-1:0]  end_time;
   logic [TIME_W-1:0]  turnaround;
   logic [TIME_W-1:0]  wait_span;
   logic               last_segment;

   modport source (output valid, run_id, start_time, end_time, turnaround, wait_span,
                   last_segment, input ready);
   modport sink   (input valid, run_id, start_time, end_time, turnaround, wait_span,
                   last_segment, output ready);
endinterface

// mode register write channel
interface njs_csr_if import njs_pkg::*; ();
   logic valid;
   logic ready;
   logic select_mode;

   modport source (output valid, select_mode, input ready);
   modport sink   (input valid, select_mode, output ready);
endinterface
`default_nettype wire

@@ sv/nonpreemptive_job_scheduler_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nonpreemptive_job_scheduler_core
// Non-preemptive shortest-job / priority scheduler over a table of jobs.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one job item per cycle into the job table memory. Jobs past
//   MAX_JOBS are dropped; the item with last_job set still starts the schedule.
//   After that item req_chan.ready stays low while the schedule is built.
//   Each segment needs one scan of the table: n reads from the memory, the
//   registered read and one pick state, and a set of n jobs takes n such
//   scans. The single read port of the table memory sets that pace, one
//   entry read at a time.
//   rsp_chan carries one item per scheduled job, last_segment on the final one.
//   Results sit in an output register; a stalled receiver holds the pick stage
//   until the register frees, and the next scan starts only after that pick.
//   csr_chan writes select_mode (0 shortest burst, 1 lowest priority number);
//   it is always ready; the user must write it only while the block is idle,
//   which the block does not check. Reset clears mode, job count, done flags,
//   clock and output valid, not the table memory; only loaded entries are read.
// ----------------------------------------------------------------------------
module nonpreemptive_job_scheduler_core import njs_pkg::*; #(
   parameter int MAX_JOBS = 16
) (
   input  logic        clock,
   input  logic        reset,
   njs_req_if.sink     req_chan,
   njs_rsp_if.source   rsp_chan,
   njs_csr_if.sink     csr_chan
);

   localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W = $clog2(MAX_JOBS + 1);

   sched_state_type     state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    seg_ff, seg_in;
   logic [CNT_W-1:0]    rd_addr_ff, rd_addr_in;
   logic [TIME_W-1:0]   clock_ff, clock_in;
   logic [MAX_JOBS-1:0] done_ff, done_in;
   logic                mode_ff;
   logic                rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]    rd_idx_ff;
   job_rec_type         rd_data_ff;
   job_rec_type         job_mem_ff [MAX_JOBS];

   logic                rsp_vld_ff, rsp_vld_in;
   logic [ID_W-1:0]     rsp_id_ff;
   logic [TIME_W-1:0]   rsp_start_ff;
   logic [TIME_W-1:0]   rsp_end_ff;
   logic [TIME_W-1:0]   rsp_turn_ff;
   logic [TIME_W-1:0]   rsp_wait_ff;
   logic                rsp_last_ff;

   logic                req_fire;
   logic                mem_we;
   job_rec_type         wr_rec;
   logic                scan_end;
   logic                pick_fire;
   logic                pick_last;
   logic                rsp_free;
   scan_ctl_type        pick_ctl;
   logic                sel_ready;
   job_rec_type         sel_rec;
   logic [IDX_W-1:0]    sel_idx;
   logic [TIME_W-1:0]   seg_start;
   logic [TIME_W-1:0]   seg_end;
   logic [TIME_W-1:0]   seg_wait;
   logic [TIME_W-1:0]   seg_turn;

   // handshakes
   assign req_chan.ready = (state_ff == ST_LOAD);
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign mem_we         = req_fire && (cnt_ff < CNT_W'(MAX_JOBS));
   assign rsp_free       = !rsp_vld_ff || rsp_chan.ready;

   always_comb begin
      wr_rec.id      = req_chan.job_id;
      wr_rec.arrival = req_chan.arrival_time;
      wr_rec.burst   = req_chan.burst_length;
      wr_rec.prio    = req_chan.job_priority;
   end

   // job table memory, written while loading, read while scanning
   always_ff @(posedge clock) begin
      if (mem_we) begin
         job_mem_ff[cnt_ff[IDX_W-1:0]] <= wr_rec;
      end
      rd_data_ff <= job_mem_ff[rd_addr_ff[IDX_W-1:0]];
      rd_idx_ff  <= rd_addr_ff[IDX_W-1:0];
   end

   // selection tracker
   assign pick_ctl.valid = rd_vld_ff;
   assign pick_ctl.clear = (req_fire && req_chan.last_job) || (pick_fire && !pick_last);

   njs_pick #(
      .IDX_W (IDX_W)
   ) u_pick (
      .clock     (clock),
      .reset     (reset),
      .ctl       (pick_ctl),
      .rec       (rd_data_ff),
      .idx       (rd_idx_ff),
      .done      (done_ff[rd_idx_ff]),
      .clock_now (clock_ff),
      .mode      (mode_ff),
      .sel_ready (sel_ready),
      .sel_rec   (sel_rec),
      .sel_idx   (sel_idx)
   );

   // segment timing; waiting time equals start minus arrival
   always_comb begin
      seg_start = sel_ready ? clock_ff : TIME_W'(sel_rec.arrival);
      seg_end   = seg_start + TIME_W'(sel_rec.burst);
      seg_wait  = seg_start - TIME_W'(sel_rec.arrival);
      seg_turn  = seg_wait + TIME_W'(sel_rec.burst);
   end

   assign scan_end  = rd_vld_ff && (CNT_W'(rd_idx_ff) == (cnt_ff - CNT_W'(1)));
   assign pick_fire = (state_ff == ST_PICK) && rsp_free;
   assign pick_last = (seg_ff + CNT_W'(1)) == cnt_ff;

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      seg_in     = seg_ff;
      rd_addr_in = rd_addr_ff;
      rd_vld_in  = 1'b0;
      clock_in   = clock_ff;
      done_in    = done_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (mem_we) cnt_in = cnt_ff + CNT_W'(1);
               if (req_chan.last_job) begin
                  state_in   = ST_SCAN;
                  seg_in     = '0;
                  rd_addr_in = '0;
               end
            end
         end
         ST_SCAN: begin
            if (rd_addr_ff < cnt_ff) begin
               rd_vld_in  = 1'b1;
               rd_addr_in = rd_addr_ff + CNT_W'(1);
            end
            if (scan_end) state_in = ST_PICK;
         end
         ST_PICK: begin
            if (pick_fire) begin
               if (pick_last) begin
                  state_in = ST_LOAD;
                  cnt_in   = '0;
                  seg_in   = '0;
                  clock_in = '0;
                  done_in  = '0;
               end else begin
                  state_in   = ST_SCAN;
                  seg_in     = seg_ff + CNT_W'(1);
                  rd_addr_in = '0;
                  clock_in   = seg_end;
                  done_in[sel_idx] = 1'b1;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         cnt_ff     <= '0;
         seg_ff     <= '0;
         rd_addr_ff <= '0;
         rd_vld_ff  <= 1'b0;
         clock_ff   <= '0;
         done_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         seg_ff     <= seg_in;
         rd_addr_ff <= rd_addr_in;
         rd_vld_ff  <= rd_vld_in;
         clock_ff   <= clock_in;
         done_ff    <= done_in;
      end
   end

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_BURST;
      end else if (csr_chan.valid && csr_chan.ready) begin
         mode_ff <= csr_chan.select_mode;
      end
   end

   // output register valid
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (pick_fire) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (pick_fire) begin
         rsp_id_ff    <= sel_rec.id;
         rsp_start_ff <= seg_start;
         rsp_end_ff   <= seg_end;
         rsp_turn_ff  <= seg_turn;
         rsp_wait_ff  <= seg_wait;
         rsp_last_ff  <= pick_last;
      end
   end

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.run_id       = rsp_id_ff;
   assign rsp_chan.start_time   = rsp_start_ff;
   assign rsp_chan.end_time     = rsp_end_ff;
   assign rsp_chan.turnaround   = rsp_turn_ff;
   assign rsp_chan.wait_span    = rsp_wait_ff;
   assign rsp_chan.last_segment = rsp_last_ff;

   // table never holds more than its depth
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_JOBS))
      else $error("job count exceeds table depth");

   // a picked job has not been served yet in this set
   a_pick_fresh: assert property (@(posedge clock) disable iff (reset)
      pick_fire |-> !done_ff[sel_idx])
      else $error("job picked twice");

   // the final segment returns the set state to empty
   a_set_clear: assert property (@(posedge clock) disable iff (reset)
      (pick_fire && pick_last) |=> (cnt_ff == '0 && done_ff == '0 && clock_ff == '0))
      else $error("set state not cleared after schedule");

   // while scheduling, segments emitted stay below the job count
   a_seg_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (seg_ff < cnt_ff))
      else $error("segment count overran job count");

   // no table read in flight while jobs are being loaded
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !rd_vld_ff)
      else $error("scan read overlaps load");

endmodule
`default_nettype wire

@@ sv/njs_pick.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// njs_pick
// Selection tracker. Sees the table one entry per cycle and keeps the best
// arrived job and the best pending job (earliest arrival, then smallest key).
// ----------------------------------------------------------------------------
module njs_pick import njs_pkg::*; #(
   parameter int IDX_W = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  scan_ctl_type       ctl,
   input  job_rec_type        rec,
   input  logic [IDX_W-1:0]   idx,
   input  logic               done,
   input  logic [TIME_W-1:0]  clock_now,
   input  logic               mode,
   output logic               sel_ready,
   output job_rec_type        sel_rec,
   output logic [IDX_W-1:0]   sel_idx
);

   logic               rdy_found_ff;
   logic [KEY_W-1:0]   rdy_key_ff;
   job_rec_type        rdy_rec_ff;
   logic [IDX_W-1:0]   rdy_idx_ff;
   logic               pnd_found_ff;
   logic [KEY_W-1:0]   pnd_key_ff;
   job_rec_type        pnd_rec_ff;
   logic [IDX_W-1:0]   pnd_idx_ff;

   logic [KEY_W-1:0]   key;
   logic               live;
   logic               take_rdy;
   logic               take_pnd;

   // candidate tests on the entry just read
   always_comb begin
      key      = key_of(rec, mode);
      live     = ctl.valid && !done;
      take_rdy = live && (TIME_W'(rec.arrival) <= clock_now) &&
                 (!rdy_found_ff || (key < rdy_key_ff));
      take_pnd = live && (!pnd_found_ff || (rec.arrival < pnd_rec_ff.arrival) ||
                 ((rec.arrival == pnd_rec_ff.arrival) && (key < pnd_key_ff)));
   end

   // found flags
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         rdy_found_ff <= 1'b0;
         pnd_found_ff <= 1'b0;
      end else begin
         if (take_rdy) rdy_found_ff <= 1'b1;
         if (take_pnd) pnd_found_ff <= 1'b1;
      end
   end

   // best candidate records
   always_ff @(posedge clock) begin
      if (take_rdy) begin
         rdy_key_ff <= key;
         rdy_rec_ff <= rec;
         rdy_idx_ff <= idx;
      end
      if (take_pnd) begin
         pnd_key_ff <= key;
         pnd_rec_ff <= rec;
         pnd_idx_ff <= idx;
      end
   end

   // an arrived job wins; otherwise time jumps to the best pending one
   assign sel_ready = rdy_found_ff;
   assign sel_rec   = rdy_found_ff ? rdy_rec_ff : pnd_rec_ff;
   assign sel_idx   = rdy_found_ff ? rdy_idx_ff : pnd_idx_ff;

endmodule
`default_nettype wire

@@ test/nonpreemptive_job_scheduler_core_test.sv @@
// ----------------------------------------------------------------------------
// nonpreemptive_job_scheduler_core_test
// Loads job sets into the scheduler and checks every schedule segment against
// a behavioral schedule built in the testbench. Covers both selection modes,
// ties, zero bursts, idle jumps in time, field extremes, a table overflow and
// random sets, with random gaps on the job side and stalls on the result side.
// ----------------------------------------------------------------------------
module nonpreemptive_job_scheduler_core_test;
   import njs_pkg::*;

   localparam int MAX_JOBS      = 16;
   localparam int SETTLE_CYCLES = 2 * (MAX_JOBS + 2) + 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;

   // mix of job contents used by the random sets
   typedef enum int {
      MIX_DENSE,
      MIX_SPARSE,
      MIX_WIDE
   } job_mix_type;

   // one expected schedule segment
   typedef struct packed {
      logic [ID_W-1:0]   run_id;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] end_time;
      logic [TIME_W-1:0] turnaround;
      logic [TIME_W-1:0] wait_span;
      logic              last_segment;
   } segment_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   njs_req_if req_chan ();
   njs_rsp_if rsp_chan ();
   njs_csr_if csr_chan ();

   nonpreemptive_job_scheduler_core #(
      .MAX_JOBS (MAX_JOBS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // schedule model state
   job_rec_type loaded_jobs[$];
   segment_type pending_segments[$];
   logic        mode_now = MODE_BURST;

   int  fail_count  = 0;
   int  cycle_count = 0;
   int  stall_left  = 0;
   bit  idle_on     = 1'b1;

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("nonpreemptive_job_scheduler_core: mismatch");
         $finish;
      end
   end

   // result side ready with random stall bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (idle_on && !reset && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("%s", msg);
   endfunction

   // segment checker
   always @(posedge clock) begin
      segment_type got;
      segment_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.run_id       = rsp_chan.run_id;
         got.start_time   = rsp_chan.start_time;
         got.end_time     = rsp_chan.end_time;
         got.turnaround   = rsp_chan.turnaround;
         got.wait_span    = rsp_chan.wait_span;
         got.last_segment = rsp_chan.last_segment;
         if (pending_segments.size() == 0) begin
            note_failure($sformatf("unexpected segment id=%0d start=%0d end=%0d",
                                   got.run_id, got.start_time, got.end_time));
         end else begin
            want = pending_segments.pop_front();
            if (got.run_id !== want.run_id || got.start_time !== want.start_time ||
                got.end_time !== want.end_time || got.turnaround !== want.turnaround ||
                got.wait_span !== want.wait_span ||
                got.last_segment !== want.last_segment)
               note_failure($sformatf({"segment mismatch: expected id=%0d start=%0d ",
                  "end=%0d turn=%0d wait=%0d last=%0d, got id=%0d start=%0d end=%0d ",
                  "turn=%0d wait=%0d last=%0d"},
                  want.run_id, want.start_time, want.end_time, want.turnaround,
                  want.wait_span, want.last_segment, got.run_id, got.start_time,
                  got.end_time, got.turnaround, got.wait_span, got.last_segment));
         end
      end
   end

   // builds the non-preemptive schedule of the loaded set
   function automatic void schedule_set();
      bit          served [MAX_JOBS];
      int unsigned now;
      int unsigned earliest;
      int unsigned best_key;
      int unsigned key;
      int unsigned turn;
      int          count;
      int          pick;
      segment_type seg;
      count = loaded_jobs.size();
      now = 0;
      foreach (served[i]) served[i] = 1'b0;
      for (int k = 0; k < count; k++) begin
         // jump to the earliest pending arrival when nothing has arrived yet
         earliest = 32'hFFFF_FFFF;
         for (int i = 0; i < count; i++)
            if (!served[i] && loaded_jobs[i].arrival < earliest)
               earliest = loaded_jobs[i].arrival;
         if (earliest > now)
            now = earliest;
         // smallest key among arrived jobs, ties to the earlier one
         pick = -1;
         best_key = 0;
         for (int i = 0; i < count; i++) begin
            if (!served[i] && loaded_jobs[i].arrival <= now) begin
               key = (mode_now == MODE_PRIO) ? loaded_jobs[i].prio : loaded_jobs[i].burst;
               if (pick < 0 || key < best_key) begin
                  pick = i;
                  best_key = key;
               end
            end
         end
         served[pick] = 1'b1;
         seg.run_id = loaded_jobs[pick].id;
         seg.start_time = TIME_W'(now);
         now += loaded_jobs[pick].burst;
         seg.end_time = TIME_W'(now);
         turn = now - loaded_jobs[pick].arrival;
         seg.turnaround = TIME_W'(turn);
         seg.wait_span = TIME_W'(turn - loaded_jobs[pick].burst);
         seg.last_segment = (k == count - 1);
         pending_segments.insert(pending_segments.size(), seg);
      end
   endfunction

   // table update for one accepted item; overflow jobs are dropped
   function automatic void load_job(input job_rec_type job, input logic last);
      if (loaded_jobs.size() < MAX_JOBS)
         loaded_jobs.insert(loaded_jobs.size(), job);
      if (last) begin
         schedule_set();
         loaded_jobs.delete();
      end
   endfunction

   function automatic job_rec_type make_job(input int id, input int arrival, input int burst,
                                            input int prio);
      job_rec_type job;
      job.id = ID_W'(id);
      job.arrival = ARR_W'(arrival);
      job.burst = BURST_W'(burst);
      job.prio = PRIO_W'(prio);
      return job;
   endfunction

   function automatic job_rec_type random_job(input job_mix_type mix);
      job_rec_type job;
      job.id = ID_W'($urandom);
      case (mix)
         MIX_DENSE: begin
            job.arrival = ARR_W'($urandom_range(0, 60));
            job.burst = BURST_W'($urandom_range(0, 40));
            job.prio = PRIO_W'($urandom_range(0, 3));
         end
         MIX_SPARSE: begin
            job.arrival = ARR_W'($urandom);
            job.burst = BURST_W'($urandom_range(0, 300));
            job.prio = PRIO_W'($urandom_range(0, 15));
         end
         default: begin
            job.arrival = ARR_W'($urandom);
            job.burst = BURST_W'($urandom);
            job.prio = PRIO_W'($urandom);
         end
      endcase
      return job;
   endfunction

   // sends one job item, with an optional gap before it
   task automatic send_job(input job_rec_type job, input logic last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.job_id <= job.id;
      req_chan.arrival_time <= job.arrival;
      req_chan.burst_length <= job.burst;
      req_chan.job_priority <= job.prio;
      req_chan.last_job <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      load_job(job, last);
   endtask

   // waits until the schedule is out and the block is back to loading
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_segments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      csr_chan.valid <= 1'b1;
      csr_chan.select_mode <= mode;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      mode_now = mode;
   endtask

   // shortest burst: zero burst, extremes, jump to a late arrival
   task automatic test_burst_mode();
      write_mode(MODE_BURST);
      send_job(make_job(8'hFF, 0, 3, 8'hFF), 1'b0);
      send_job(make_job(0, 0, 0, 0), 1'b0);
      send_job(make_job(2, 1, 3, 7), 1'b0);
      send_job(make_job(8'h5A, 16'hFFFF, 16'hFFFF, 8'hA5), 1'b1);
      drain();
   endtask

   // lowest priority number: ties, late high-priority arrival
   task automatic test_priority_mode();
      write_mode(MODE_PRIO);
      send_job(make_job(10, 0, 9, 5), 1'b0);
      send_job(make_job(11, 0, 1, 5), 1'b0);
      send_job(make_job(12, 4, 2, 0), 1'b0);
      send_job(make_job(13, 0, 16'h8000, 8'hFF), 1'b1);
      drain();
   endtask

   // full table: the job past the limit is dropped, its last mark still counts
   task automatic test_table_overflow();
      write_mode(MODE_BURST);
      for (int i = 0; i < MAX_JOBS; i++)
         send_job(make_job(i * 16 + 1, 0, (i * 7) % 5, i), 1'b0);
      send_job(make_job(8'hAA, 0, 0, 0), 1'b1);
      drain();
   endtask

   // random sets with mode changes between them
   task automatic test_random_sets(input int item_total);
      int          sent;
      int          set_size;
      int          roll;
      job_mix_type mix;
      sent = 0;
      while (sent < item_total) begin
         if ($urandom_range(0, 2) == 0)
            write_mode(logic'($urandom_range(0, 1)));
         roll = $urandom_range(0, 19);
         if (roll < 12)
            set_size = $urandom_range(1, 6);
         else if (roll < 18)
            set_size = $urandom_range(7, MAX_JOBS);
         else
            set_size = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
         mix = job_mix_type'($urandom_range(0, 2));
         for (int i = 0; i < set_size; i++)
            send_job(random_job(mix), i == set_size - 1);
         sent += set_size;
         drain();
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.job_id = '0;
      req_chan.arrival_time = '0;
      req_chan.burst_length = '0;
      req_chan.job_priority = '0;
      req_chan.last_job = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.select_mode = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_burst_mode();
      test_priority_mode();
      test_table_overflow();
      test_random_sets(210);
      // closing stretch with no gaps or stalls
      idle_on = 1'b0;
      test_random_sets(30);

      if (pending_segments.size() != 0)
         note_failure($sformatf("%0d segments never arrived", pending_segments.size()));
      if (fail_count == 0)
         $display("nonpreemptive_job_scheduler_core: match");
      else
         $display("nonpreemptive_job_scheduler_core: mismatch");
      $finish;
   end

endmodule
